FILE: hdl/mbct_pkg.sv
// Shared types and constants for the beat clock timeline block.
// Depends on nothing; every other file in hdl imports it.
`default_nettype none

package mbct_pkg;

	localparam int unsigned TICKS_PER_BEAT       = 24;
	localparam int unsigned RATE_HZ              = 44100;
	localparam int unsigned DEFAULT_BEAT_SAMPLES = 22050;
	localparam int unsigned US_PER_S             = 1000000;
	localparam int unsigned TEMPO_MIN            = 8000;
	localparam int unsigned TEMPO_MAX            = 100000;
	localparam int unsigned TEMPO_SCALE          = TICKS_PER_BEAT * RATE_HZ;
	localparam int unsigned BAR_BEATS_MAX        = 16;

	// register reset values
	localparam logic [4:0]  BPB_RESET    = 5'd4;
	localparam logic [16:0] SUB_RESET    = 17'd11025;
	localparam logic [7:0]  GRACE_RESET  = 8'd16;
	localparam logic [9:0]  WINDOW_RESET = 10'd128;

	// serial divider widths
	localparam int unsigned DV_W  = 64;
	localparam int unsigned DS_W  = 21;
	localparam int unsigned CNT_W = 7;

	typedef enum logic [2:0] {
		REQ_ADVANCE = 3'd0,
		REQ_TICK    = 3'd1,
		REQ_SYNC    = 3'd2,
		REQ_SET     = 3'd3,
		REQ_POLL    = 3'd4,
		REQ_RESET   = 3'd5
	} req_code_t;

	localparam logic [1:0] MODE_PLAY = 2'd1;
	localparam logic [1:0] MODE_REC  = 2'd2;

	typedef struct packed {
		logic [4:0]  bar_beats;
		logic [16:0] subdivision_samples;
		logic [7:0]  grace_samples;
		logic [9:0]  boundary_window;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  req_type;
		logic [15:0] sample_count;
		logic [19:0] tick_period_us;
		logic [1:0]  transport_mode;
	} evt_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] position;
		logic [31:0] beat_index;
		logic [4:0]  tick_index;
		logic [16:0] beat_length;
		logic [16:0] to_next_beat;
		logic [20:0] to_next_bar;
		logic [16:0] to_next_subdivision;
		logic        on_beat;
		logic        on_bar;
		logic        beat_seen;
		logic        running;
		logic        tempo_taken;
	} res_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] nbits;
		logic [DV_W-1:0]  dividend;
		logic [DS_W-1:0]  divisor;
	} dv_req_t;

	typedef struct packed {
		logic            done;
		logic [DV_W-1:0] quot;
		logic [DS_W-1:0] rem;
	} dv_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/mbct_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mbct_pkg.
`default_nettype none

module mbct_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mbct_pkg::dv_req_t req,
	output      mbct_pkg::dv_rsp_t rsp
);
	import mbct_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DS_W-1:0]  rem_q;
	logic [DS_W-1:0]  dvs_q;
	logic [DV_W-1:0]  dq_q;

	logic [DS_W:0] trial;
	logic [DS_W:0] diff;
	logic          ge;

	assign trial = {rem_q, dq_q[DV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			dq_q  <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DS_W-1:0] : trial[DS_W-1:0];
			dq_q  <= {dq_q[DV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

FILE: hdl/mbct_core.sv
// Timeline state and the step sequencer that drives the serial divider.
// Depends on mbct_pkg and mbct_div.
`default_nettype none

module mbct_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mbct_pkg::cfg_t cfg,
	input  wire mbct_pkg::evt_t evt,
	output      logic           evt_ready,
	output      mbct_pkg::res_t res,
	input  wire logic           res_ready
);
	import mbct_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_TMUL, S_TDIV_GO, S_TDIV_WAIT, S_MUL1,
		S_D1_GO, S_D1_WAIT, S_D2_GO, S_D2_WAIT, S_D3_GO, S_D3_WAIT,
		S_MUL2, S_D4_GO, S_D4_WAIT, S_MUL3, S_D5_GO, S_D5_WAIT,
		S_FIN, S_DONE
	} state_t;

	state_t state_q;

	logic [63:0] pos_q;
	logic [31:0] beat_q;
	logic [4:0]  tick_q;
	logic [16:0] spb_q;
	logic [1:0]  mode_q;
	logic        pend_q;
	logic        seen_q;
	logic        taken_q;
	logic [19:0] period_q;
	logic [40:0] prod_q;
	logic [20:0] barlen_q;
	logic [48:0] bstart_q;
	logic [16:0] to_beat_q;
	logic [20:0] to_bar_q;
	logic [12:0] q24_q;
	logic [16:0] elapsed_q;
	logic [16:0] subq_q;
	logic [16:0] to_sub_q;
	logic        barzero_q;
	logic        on_beat_q;
	logic        on_bar_q;
	dv_req_t     dv_req_q;
	dv_rsp_t     dv_rsp;

	logic [4:0]  bpb_eff;
	logic [16:0] sub_eff;
	logic        wrap;
	logic [17:0] elapsed_raw;
	logic [34:0] next_raw;
	logic [16:0] next_cl;
	logic [63:0] pos_diff;

	assign bpb_eff = (cfg.bar_beats == 5'd0) ? 5'd1 :
		(cfg.bar_beats > 5'(BAR_BEATS_MAX)) ? 5'(BAR_BEATS_MAX) : cfg.bar_beats;
	assign sub_eff = (cfg.subdivision_samples == 17'd0) ? 17'd1 : cfg.subdivision_samples;
	assign wrap    = (evt.req_type == REQ_TICK) && (tick_q >= 5'(TICKS_PER_BEAT - 1));
	assign elapsed_raw = 18'(tick_q) * 18'(q24_q);
	assign next_raw    = 35'(18'(subq_q) + 18'd1) * 35'(sub_eff);
	assign next_cl     = (next_raw > 35'(spb_q)) ? spb_q : next_raw[16:0];
	assign pos_diff    = pos_q - 64'(bstart_q);

	mbct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dv_req_q),
		.rsp    (dv_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= '0;
			beat_q   <= '0;
			tick_q   <= '0;
			spb_q    <= 17'(DEFAULT_BEAT_SAMPLES);
			mode_q   <= '0;
			pend_q   <= 1'b0;
			seen_q   <= 1'b0;
			taken_q  <= 1'b0;
			dv_req_q <= '0;
		end else begin
			dv_req_q.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (evt.valid) begin
						period_q <= evt.tick_period_us;
						taken_q  <= 1'b0;
						seen_q   <= wrap | pend_q;
						if (evt.req_type == REQ_POLL) begin
							pend_q <= 1'b0;
						end else if (wrap) begin
							pend_q <= 1'b1;
						end
						case (evt.req_type)
							REQ_ADVANCE: pos_q <= pos_q + 64'(evt.sample_count);
							REQ_TICK: begin
								if (wrap) begin
									tick_q <= '0;
									beat_q <= beat_q + 32'd1;
								end else begin
									tick_q <= tick_q + 5'd1;
								end
							end
							REQ_SET: mode_q <= evt.transport_mode;
							REQ_RESET: begin
								pos_q  <= '0;
								beat_q <= '0;
								tick_q <= '0;
								spb_q  <= 17'(DEFAULT_BEAT_SAMPLES);
								mode_q <= '0;
							end
							default: ;
						endcase
						state_q <= (evt.req_type == REQ_SYNC) ? S_TMUL : S_MUL1;
					end
				end
				S_TMUL: begin
					prod_q  <= 41'(period_q) * 41'(TEMPO_SCALE);
					state_q <= S_TDIV_GO;
				end
				S_TDIV_GO: begin
					dv_req_q <= {1'b1, CNT_W'(41), {prod_q, 23'd0}, DS_W'(US_PER_S)};
					state_q  <= S_TDIV_WAIT;
				end
				S_TDIV_WAIT: begin
					if (dv_rsp.done) begin
						if (dv_rsp.quot >= 64'(TEMPO_MIN) && dv_rsp.quot <= 64'(TEMPO_MAX)) begin
							spb_q   <= dv_rsp.quot[16:0];
							taken_q <= 1'b1;
						end
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					barlen_q <= 21'(spb_q) * 21'(bpb_eff);
					bstart_q <= 49'(beat_q) * 49'(spb_q);
					state_q  <= S_D1_GO;
				end
				S_D1_GO: begin
					dv_req_q <= {1'b1, CNT_W'(64), pos_q, DS_W'(spb_q)};
					state_q  <= S_D1_WAIT;
				end
				S_D1_WAIT: begin
					if (dv_rsp.done) begin
						to_beat_q <= (dv_rsp.rem <= DS_W'(cfg.grace_samples)) ? 17'd0 :
							spb_q - dv_rsp.rem[16:0];
						state_q <= S_D2_GO;
					end
				end
				S_D2_GO: begin
					dv_req_q <= {1'b1, CNT_W'(64), pos_q, barlen_q};
					state_q  <= S_D2_WAIT;
				end
				S_D2_WAIT: begin
					if (dv_rsp.done) begin
						to_bar_q <= (dv_rsp.rem <= DS_W'(cfg.grace_samples)) ? 21'd0 :
							barlen_q - dv_rsp.rem;
						state_q <= S_D3_GO;
					end
				end
				S_D3_GO: begin
					dv_req_q <= {1'b1, CNT_W'(17), {spb_q, 47'd0}, DS_W'(TICKS_PER_BEAT)};
					state_q  <= S_D3_WAIT;
				end
				S_D3_WAIT: begin
					if (dv_rsp.done) begin
						q24_q   <= dv_rsp.quot[12:0];
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					elapsed_q <= (elapsed_raw > 18'(spb_q)) ? spb_q : elapsed_raw[16:0];
					state_q   <= S_D4_GO;
				end
				S_D4_GO: begin
					if (sub_eff >= spb_q) begin
						to_sub_q <= spb_q - elapsed_q;
						state_q  <= S_D5_GO;
					end else begin
						dv_req_q <= {1'b1, CNT_W'(17), {elapsed_q, 47'd0}, DS_W'(sub_eff)};
						state_q  <= S_D4_WAIT;
					end
				end
				S_D4_WAIT: begin
					if (dv_rsp.done) begin
						subq_q  <= dv_rsp.quot[16:0];
						state_q <= S_MUL3;
					end
				end
				S_MUL3: begin
					to_sub_q <= next_cl - elapsed_q;
					state_q  <= S_D5_GO;
				end
				S_D5_GO: begin
					dv_req_q <= {1'b1, CNT_W'(32), {beat_q, 32'd0}, DS_W'(bpb_eff)};
					state_q  <= S_D5_WAIT;
				end
				S_D5_WAIT: begin
					if (dv_rsp.done) begin
						barzero_q <= (dv_rsp.rem == '0);
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					on_beat_q <= (pos_q >= 64'(bstart_q)) &&
						(pos_diff <= 64'(cfg.boundary_window));
					on_bar_q  <= (pos_q >= 64'(bstart_q)) &&
						(pos_diff <= 64'(cfg.boundary_window)) && barzero_q;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt_ready = (state_q == S_IDLE);

	assign res.valid               = (state_q == S_DONE);
	assign res.position            = pos_q;
	assign res.beat_index          = beat_q;
	assign res.tick_index          = tick_q;
	assign res.beat_length         = spb_q;
	assign res.to_next_beat        = to_beat_q;
	assign res.to_next_bar         = to_bar_q;
	assign res.to_next_subdivision = to_sub_q;
	assign res.on_beat             = on_beat_q;
	assign res.on_bar              = on_bar_q;
	assign res.beat_seen           = seen_q;
	assign res.running             = (mode_q == MODE_PLAY) || (mode_q == MODE_REC);
	assign res.tempo_taken         = taken_q;

`ifndef SYNTH
	a_spb_range: assert property (@(posedge clk) disable iff (!arst_n)
		spb_q >= 17'(TEMPO_MIN) && spb_q <= 17'(TEMPO_MAX))
		else $error("beat length left its range");
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < 5'(TICKS_PER_BEAT))
		else $error("tick position past beat end");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(evt_ready && res.valid))
		else $error("result pending while accepting beats");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dv_req_q.start |-> !(state_q == S_IDLE || state_q == S_DONE))
		else $error("divider started outside the sequence");
`endif

endmodule

`default_nettype wire

FILE: hdl/midi_beat_clock_timeline_top.sv
// Beat clock timeline: configuration registers, stream handshake, result register.
// Depends on mbct_pkg, mbct_core (and mbct_div below it).
// A tempo sync adds one 41-bit tempo divide; the subdivision divide is skipped when
// the subdivision is not shorter than the beat. One beat in flight: the next is taken
// in the cycle after the result moves to the output register. Time is set by the shared
// bit-serial divider: two 64-bit modulos and up to three short divides per event, plus
// the tempo divide for a sync. Reset: arst_n clears at once, no pass.
`default_nettype none

module midi_beat_clock_timeline_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// configuration port
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output      logic [31:0]   prdata,
	output      logic          pready,
	// input events
	input  wire logic          s_axis_tvalid,
	output      logic          s_axis_tready,
	// [15:0] sample_count, [35:16] tick_period_us, [37:36] transport_mode, [39:38] zero
	input  wire logic [39:0]   s_axis_tdata,
	// [2:0] req_type
	input  wire logic [2:0]    s_axis_tuser,
	// results
	output      logic          m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// [63:0] position, [95:64] beat_index, [100:96] tick_index,
	// [117:101] beat_length, [134:118] to_next_beat, [155:135] to_next_bar,
	// [172:156] to_next_subdivision, [173] on_beat, [174] on_bar,
	// [175] beat_seen, [176] running, [177] tempo_taken, [183:178] zero
	output      logic [183:0]  m_axis_tdata
);
	import mbct_pkg::*;

	typedef enum logic [1:0] {
		REG_BPB    = 2'd0,
		REG_SUB    = 2'd1,
		REG_GRACE  = 2'd2,
		REG_WINDOW = 2'd3
	} reg_idx_t;

	cfg_t         cfg_q;
	evt_t         evt;
	res_t         res;
	logic         evt_ready;
	logic         res_ready;
	logic         wr_en;
	logic         mvalid_q;
	logic [183:0] mdata_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// register file; upper address bits pick the register, byte lanes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bar_beats           <= BPB_RESET;
			cfg_q.subdivision_samples <= SUB_RESET;
			cfg_q.grace_samples       <= GRACE_RESET;
			cfg_q.boundary_window     <= WINDOW_RESET;
		end else if (wr_en) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_BPB:    cfg_q.bar_beats           <= pwdata[4:0];
				REG_SUB:    cfg_q.subdivision_samples <= pwdata[16:0];
				REG_GRACE:  cfg_q.grace_samples       <= pwdata[7:0];
				REG_WINDOW: cfg_q.boundary_window     <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_BPB:    prdata = 32'(cfg_q.bar_beats);
			REG_SUB:    prdata = 32'(cfg_q.subdivision_samples);
			REG_GRACE:  prdata = 32'(cfg_q.grace_samples);
			REG_WINDOW: prdata = 32'(cfg_q.boundary_window);
			default:    prdata = '0;
		endcase
	end

	// unpack the input beat; the core takes it only while idle
	assign evt.valid          = s_axis_tvalid;
	assign evt.req_type       = s_axis_tuser;
	assign evt.sample_count   = s_axis_tdata[15:0];
	assign evt.tick_period_us = s_axis_tdata[35:16];
	assign evt.transport_mode = s_axis_tdata[37:36];
	assign s_axis_tready      = evt_ready;

	mbct_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt       (evt),
		.evt_ready (evt_ready),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register: load whenever it is empty or being drained
	assign res_ready = !mvalid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (res_ready) begin
			mvalid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			mdata_q <= {6'd0, res.tempo_taken, res.running, res.beat_seen, res.on_bar,
				res.on_beat, res.to_next_subdivision, res.to_next_bar, res.to_next_beat,
				res.beat_length, res.tick_index, res.beat_index, res.position};
		end
	end

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = mdata_q;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for midi_beat_clock_timeline_top: predicts each result beat
// from the event stream and compares it field by field. Depends on mbct_pkg and the top.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mbct_pkg::*;

	typedef struct {
		logic [2:0]  req;
		logic [15:0] count;
		logic [19:0] period;
		logic [1:0]  mode;
	} event_t;

	typedef struct {
		logic [63:0] position;
		logic [31:0] beat_index;
		logic [4:0]  tick_index;
		logic [16:0] beat_length;
		logic [16:0] to_next_beat;
		logic [20:0] to_next_bar;
		logic [16:0] to_next_subdivision;
		logic        on_beat, on_bar, beat_seen, running, tempo_taken;
	} timeline_t;

	localparam logic [3:0] ADDR_BPB = 4'd0, ADDR_SUB = 4'd4, ADDR_GRACE = 4'd8,
		ADDR_WINDOW = 4'd12;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic s_axis_tvalid, s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [183:0] m_axis_tdata;

	midi_beat_clock_timeline_top dut (.*);

	// predictor state and register shadow
	logic [4:0]  bpb_q = BPB_RESET;
	logic [16:0] sub_q = SUB_RESET;
	logic [7:0]  grace_q = GRACE_RESET;
	logic [9:0]  window_q = WINDOW_RESET;
	logic [63:0] pos_q;
	logic [31:0] beats_q;
	logic [4:0]  tick_q;
	logic [16:0] spb_q;
	logic [1:0]  transport_q;
	logic        pending_q;

	event_t    event_queue[$];
	timeline_t timeline_queue[$];
	int        errors = 0;
	int        send_idle = 0, recv_idle = 0;

	// handshake sampled at the rising edge for the driver
	logic s_axis_tready_seen;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic timeline_t advance_timeline(event_t e);
		timeline_t r;
		logic [63:0] cand, bar_len, nxt, beat_start;
		logic [31:0] spb, bpb, pos_rem, elapsed, sub;
		r.tempo_taken = 0;
		case (e.req)
			REQ_ADVANCE: pos_q += 64'(e.count);
			REQ_TICK: begin
				tick_q++;
				if (tick_q >= TICKS_PER_BEAT) begin
					tick_q = 0;
					beats_q++;
					pending_q = 1;
				end
			end
			REQ_SYNC: begin
				cand = (64'(e.period) * TEMPO_SCALE) / US_PER_S;
				if (cand >= TEMPO_MIN && cand <= TEMPO_MAX) begin
					spb_q = cand[16:0];
					r.tempo_taken = 1;
				end
			end
			REQ_SET: transport_q = e.mode;
			REQ_RESET: begin
				pos_q = 0; beats_q = 0; tick_q = 0;
				spb_q = 17'(DEFAULT_BEAT_SAMPLES); transport_q = 0;
			end
			default: ;
		endcase
		r.beat_seen = pending_q;
		if (e.req == REQ_POLL) pending_q = 0;
		spb = (spb_q == 0) ? 1 : 32'(spb_q);
		bpb = (bpb_q == 0) ? 1 : (bpb_q > BAR_BEATS_MAX) ? BAR_BEATS_MAX : 32'(bpb_q);
		pos_rem = 32'(pos_q % spb);
		r.to_next_beat = (pos_rem <= grace_q) ? 0 : 17'(spb - pos_rem);
		bar_len = 64'(spb) * bpb;
		pos_rem = 32'(pos_q % bar_len);
		r.to_next_bar = (pos_rem <= grace_q) ? 0 : 21'(bar_len - pos_rem);
		sub = (sub_q == 0) ? 1 : 32'(sub_q);
		elapsed = 32'(tick_q) * (spb / TICKS_PER_BEAT);
		if (elapsed > spb) elapsed = spb;
		if (sub >= spb) r.to_next_subdivision = 17'(spb - elapsed);
		else begin
			nxt = (64'(elapsed / sub) + 1) * sub;
			if (nxt > spb) nxt = spb;
			r.to_next_subdivision = 17'(nxt - elapsed);
		end
		beat_start = 64'(beats_q) * spb;
		r.on_beat = (pos_q >= beat_start) && (pos_q - beat_start <= 64'(window_q));
		r.on_bar = r.on_beat && (beats_q % bpb == 0);
		r.position = pos_q;
		r.beat_index = beats_q;
		r.tick_index = tick_q;
		r.beat_length = spb_q;
		r.running = (transport_q == MODE_PLAY) || (transport_q == MODE_REC);
		return r;
	endfunction

	// driver: present the next queued event, predict it once accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready_seen) begin
				timeline_queue.push_back(advance_timeline(event_queue.pop_front()));
			end
			if (event_queue.size() > 0 && (!s_axis_tvalid || s_axis_tready_seen)
					&& $urandom_range(99) >= send_idle) begin
				s_axis_tvalid <= 1;
				s_axis_tuser <= event_queue[0].req;
				s_axis_tdata <= {2'b0, event_queue[0].mode, event_queue[0].period,
					event_queue[0].count};
			end else if (!s_axis_tvalid || s_axis_tready_seen) begin
				s_axis_tvalid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) s_axis_tready_seen <= 0;
		else s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
	end

	// receiver stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tready <= 0;
		else m_axis_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// monitor: compare every result beat with the oldest prediction
	always @(posedge clk) begin
		timeline_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (timeline_queue.size() == 0) begin
				$error("result beat with no prediction pending");
				errors++;
			end else begin
				w = timeline_queue.pop_front();
				check_field("position", w.position, m_axis_tdata[63:0]);
				check_field("beat_index", w.beat_index, m_axis_tdata[95:64]);
				check_field("tick_index", w.tick_index, m_axis_tdata[100:96]);
				check_field("beat_length", w.beat_length, m_axis_tdata[117:101]);
				check_field("to_next_beat", w.to_next_beat, m_axis_tdata[134:118]);
				check_field("to_next_bar", w.to_next_bar, m_axis_tdata[155:135]);
				check_field("to_next_subdivision", w.to_next_subdivision,
					m_axis_tdata[172:156]);
				check_field("on_beat", w.on_beat, m_axis_tdata[173]);
				check_field("on_bar", w.on_bar, m_axis_tdata[174]);
				check_field("beat_seen", w.beat_seen, m_axis_tdata[175]);
				check_field("running", w.running, m_axis_tdata[176]);
				check_field("tempo_taken", w.tempo_taken, m_axis_tdata[177]);
			end
		end
	end

	// one register write, setup then access; update the shadow copy
	task automatic write_reg(logic [3:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= addr; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (addr)
			ADDR_BPB:    bpb_q = value[4:0];
			ADDR_SUB:    sub_q = value[16:0];
			ADDR_GRACE:  grace_q = value[7:0];
			ADDR_WINDOW: window_q = value[9:0];
			default: ;
		endcase
	endtask

	task automatic push_event(logic [2:0] req, logic [15:0] count, logic [19:0] period,
			logic [1:0] mode);
		event_t e;
		e.req = req; e.count = count; e.period = period; e.mode = mode;
		event_queue.push_back(e);
	endtask

	// hold until the block has drained everything, then a little longer
	task automatic wait_drained();
		wait (event_queue.size() == 0 && !s_axis_tvalid && timeline_queue.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	// mostly ticks and advances, so beats and bars really get crossed
	task automatic random_events(int n);
		int k;
		logic [2:0] req;
		logic [19:0] period;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 35) req = REQ_TICK;
			else if (k < 65) req = REQ_ADVANCE;
			else if (k < 75) req = REQ_SYNC;
			else if (k < 83) req = REQ_POLL;
			else if (k < 91) req = REQ_SET;
			else if (k < 96) req = REQ_RESET;
			else req = 3'($urandom_range(7));
			// near-range periods most of the time, raw bits otherwise
			period = ($urandom_range(3) != 0) ? 20'($urandom_range(7400, 95000))
				: 20'($urandom);
			push_event(req, ($urandom_range(1) ? 16'($urandom_range(3000)) : 16'($urandom)),
				period, 2'($urandom));
		end
	endtask

	initial begin
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		pos_q = 0; beats_q = 0; tick_q = 0; spb_q = 17'(DEFAULT_BEAT_SAMPLES);
		transport_q = 0; pending_q = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes, every request, special cases
		push_event(REQ_ADVANCE, 16'hFFFF, 20'hFFFFF, 2'd3);
		push_event(REQ_ADVANCE, 16'h0000, 20'h0, 2'd0);
		for (int i = 0; i < 24; i++) push_event(REQ_TICK, 16'h5555, 20'hAAAAA, 2'd1);
		push_event(REQ_POLL, 0, 0, 0);
		push_event(REQ_POLL, 0, 0, 0);
		push_event(REQ_SYNC, 0, 20'd7558, 0);   // just below the tempo floor
		push_event(REQ_SYNC, 0, 20'd7559, 0);
		push_event(REQ_SYNC, 0, 20'd94483, 0);  // top of the range
		push_event(REQ_SYNC, 0, 20'd94484, 0);
		push_event(REQ_SYNC, 0, 20'hFFFFF, 0);
		push_event(REQ_SET, 0, 0, 2'd1);
		push_event(REQ_SET, 0, 0, 2'd2);
		push_event(REQ_SET, 0, 0, 2'd3);
		push_event(3'd6, 16'hFFFF, 0, 0);
		push_event(3'd7, 0, 0, 0);
		push_event(REQ_RESET, 0, 0, 0);
		wait_drained();

		// register settings, extremes included, under the first idle pattern
		send_idle = 29; recv_idle = 75;
		write_reg(ADDR_BPB, 0); write_reg(ADDR_SUB, 0);
		write_reg(ADDR_GRACE, 255); write_reg(ADDR_WINDOW, 1023);
		random_events(300);
		wait_drained();
		write_reg(ADDR_BPB, 31); write_reg(ADDR_SUB, 100000);
		write_reg(ADDR_GRACE, 0); write_reg(ADDR_WINDOW, 0);
		random_events(300);
		wait_drained();

		send_idle = 75; recv_idle = 29;
		write_reg(ADDR_BPB, 16); write_reg(ADDR_SUB, 131071);
		write_reg(ADDR_GRACE, 8'($urandom)); write_reg(ADDR_WINDOW, 10'($urandom));
		random_events(300);
		wait_drained();

		send_idle = 0; recv_idle = 0;
		write_reg(ADDR_BPB, 1); write_reg(ADDR_SUB, 917);
		write_reg(ADDR_GRACE, 16); write_reg(ADDR_WINDOW, 128);
		random_events(250);
		wait_drained();
		write_reg(ADDR_BPB, 5'($urandom_range(2, 15)));
		write_reg(ADDR_SUB, 17'($urandom_range(1, 30000)));
		random_events(250);
		wait_drained();

		if (errors == 0) $display("midi_beat_clock_timeline_top: match");
		else $display("midi_beat_clock_timeline_top: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("midi_beat_clock_timeline_top: mismatch");
		$finish;
	end
endmodule

`default_nettype wire

FILE: files.f
hdl/mbct_pkg.sv
hdl/mbct_div.sv
hdl/mbct_core.sv
hdl/midi_beat_clock_timeline_top.sv
sim/tb.sv
